@@ design/kpi_pkg.sv @@
// Package: sizes, action codes and shared types for the keyframe pose interpolator.
package kpi_pkg;
	localparam int MAX_KEYS = 64;
	localparam int MAX_JOINTS = 32;
	localparam int KEY_W = $clog2(MAX_KEYS);
	localparam int JNT_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int MAT_AW = KEY_W + JNT_W + 4;
	localparam int CNT_W = 7;

	typedef enum logic [1:0] {
		ACT_WTIME = 2'd0,
		ACT_WELEM = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// one matrix store access
	typedef struct packed {
		logic              we;
		logic [MAT_AW-1:0] addr;
		logic [31:0]       wdata;
	} mat_req_t;
endpackage

@@ design/keyframe_pose_interpolator.sv @@
// Top level: keyframe table with linear interpolation of per-joint 4x4 matrices.
//
// Input channel: a word is taken at a clock edge where start is high and busy is
// low. action 0 writes a key time, action 1 writes one matrix element, action 2
// queries the pose of joint_id at query_time. Writes can follow back to back.
// A query returns four rows, one per strobe cycle, row 0 first, last_row on
// row 3; the receiver cannot stall, every strobe cycle carries a row.
// Query steps: the key time scan reads one key per cycle, states ST_RDLO and
// ST_LOT fetch the lower key time, a fraction divide runs only when the time
// lies strictly inside an interval, then 32 matrix store reads, one element
// per cycle, feed a two-stage mix. busy stays high for the whole query and
// falls after row 3.
// Configuration: cfg_valid/cfg_ready write keys_in_use; ready is high while
// idle. Reset sets keys_in_use to 2 and the controller idle; both tables are
// undefined until written and need no clearing pass.
module keyframe_pose_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [5:0]  key_slot,
	input  logic [4:0]  joint_id,
	input  logic [3:0]  element_slot,
	input  logic signed [31:0] write_value,
	input  logic [31:0] query_time,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	output logic        strobe,
	output logic [4:0]  out_joint,
	output logic [1:0]  row_number,
	output logic signed [31:0] elem_a,
	output logic signed [31:0] elem_b,
	output logic signed [31:0] elem_c,
	output logic signed [31:0] elem_d,
	output logic        last_row
);
	import kpi_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_RDLO, ST_LOT, ST_DIV, ST_MAT, ST_DRAIN
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] keys_q;
	logic [31:0] ktime [0:MAX_KEYS-1];
	logic [31:0] krd_q;
	logic [KEY_W-1:0] kaddr;
	logic [KEY_W:0] idx_q;
	logic [KEY_W-1:0] lo_q;
	logic [KEY_W:0] nkeys;
	logic found_q;
	logic [31:0] t_q, tlo_q, thi_q;
	logic [4:0] jnt_q;
	logic [16:0] f_q;
	logic div_go, div_done;
	logic [16:0] div_quo;
	mat_req_t mreq;
	logic [31:0] mrd;
	logic [5:0] mcnt_q;   // bit0: key (lo/hi), [4:1]: element
	logic [5:0] rcnt_s1;
	logic rval_s1;
	logic [31:0] a_q;
	logic signed [32:0] dif;
	logic signed [50:0] prod_s2;
	logic signed [31:0] a_s2;
	logic v_s2;
	logic [5:0] c_s2;
	logic [31:0] row_q [0:2];
	logic in_acc;
	logic jok;

	assign in_acc = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign jok = ({3'd0, joint_id} < 8'(MAX_JOINTS));

	always_comb begin
		if (keys_q < CNT_W'(2)) nkeys = (KEY_W+1)'(2);
		else if ({{(32-CNT_W){1'b0}}, keys_q} > 32'(MAX_KEYS)) nkeys = (KEY_W+1)'(MAX_KEYS);
		else nkeys = (KEY_W+1)'(keys_q);
	end

	// key time table read port
	always_comb begin
		kaddr = idx_q[KEY_W-1:0];
		if (state_q == ST_RDLO) kaddr = lo_q;
	end

	always_ff @(posedge clk) begin
		if (in_acc && action == ACT_WTIME) begin
			ktime[key_slot[KEY_W-1:0]] <= write_value;
		end
		krd_q <= ktime[kaddr];
	end

	always_comb begin
		mreq.we    = in_acc && action == ACT_WELEM && jok;
		mreq.wdata = write_value;
		mreq.addr  = {key_slot[KEY_W-1:0], joint_id[JNT_W-1:0], element_slot};
		if (state_q == ST_MAT) begin
			mreq.addr = {mcnt_q[0] ? KEY_W'(lo_q + 1'b1) : lo_q, jnt_q[JNT_W-1:0],
				mcnt_q[4:1]};
		end
	end

	kpi_mat_ram u_ram (.clk(clk), .req(mreq), .rdata(mrd));

	assign div_go = (state_q == ST_LOT) && found_q && (t_q > krd_q);
	kpi_divider u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go),
		.num(t_q - krd_q), .den(thi_q - krd_q),
		.done(div_done), .quo(div_quo)
	);

	// scan reads are registered and lag: past idx_q 1, krd_q holds ktime[idx_q-1]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			keys_q  <= CNT_W'(2);
			rval_s1 <= 1'b0;
		end else begin
			rval_s1 <= 1'b0;
			if (cfg_valid && cfg_ready) keys_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && action == ACT_QUERY && jok) begin
						state_q <= ST_SCAN;
						idx_q   <= (KEY_W+1)'(1);
						t_q     <= query_time;
						jnt_q   <= joint_id;
						found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (idx_q != (KEY_W+1)'(1) && krd_q > t_q) begin
						found_q <= 1'b1;
						thi_q   <= krd_q;
						lo_q    <= KEY_W'(idx_q - 2'd2);
						state_q <= ST_RDLO;
					end else if (idx_q == nkeys) begin
						lo_q    <= KEY_W'(nkeys - 2'd2);
						state_q <= ST_RDLO;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_RDLO: begin
					state_q <= ST_LOT;
				end
				ST_LOT: begin
					// krd_q is ktime[lo] in this cycle
					if (!found_q) begin
						f_q <= 17'h10000;
						state_q <= ST_MAT;
						mcnt_q <= '0;
					end else if (t_q <= krd_q) begin
						f_q <= '0;
						state_q <= ST_MAT;
						mcnt_q <= '0;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						f_q <= div_quo;
						state_q <= ST_MAT;
						mcnt_q <= '0;
					end
				end
				ST_MAT: begin
					rval_s1 <= 1'b1;
					rcnt_s1 <= mcnt_q;
					mcnt_q  <= mcnt_q + 1'b1;
					if (mcnt_q == 6'd31) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (strobe && last_row) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// mix: a + floor((b-a)*f/2^16)
	assign dif = $signed({mrd[31], mrd}) - $signed({a_q[31], a_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			strobe <= 1'b0;
		end else begin
			v_s2   <= rval_s1 && rcnt_s1[0];
			strobe <= v_s2 && c_s2[2:1] == 2'd3;
		end
	end

	always_ff @(posedge clk) begin
		if (rval_s1 && !rcnt_s1[0]) a_q <= mrd;
		prod_s2 <= $signed({{18{dif[32]}}, dif}) * $signed({34'd0, f_q});
		a_s2    <= a_q;
		c_s2    <= rcnt_s1;
		if (v_s2) begin
			case (c_s2[2:1])
				2'd0: row_q[0] <= a_s2 + 32'(prod_s2 >>> 16);
				2'd1: row_q[1] <= a_s2 + 32'(prod_s2 >>> 16);
				2'd2: row_q[2] <= a_s2 + 32'(prod_s2 >>> 16);
				default: begin
					elem_a <= row_q[0];
					elem_b <= row_q[1];
					elem_c <= row_q[2];
					elem_d <= a_s2 + 32'(prod_s2 >>> 16);
					row_number <= c_s2[4:3];
					last_row <= (c_s2[4:3] == 2'd3);
					out_joint <= jnt_q;
				end
			endcase
		end
	end

	a_busy_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !busy) else $error("cfg ready while busy");
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("row outside query");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_row |=> !busy) else $error("busy after last row");
endmodule

@@ design/kpi_mat_ram.sv @@
// Matrix element store: single port synchronous RAM with a registered read.
module kpi_mat_ram (
	input  logic             clk,
	input  kpi_pkg::mat_req_t req,
	output logic [31:0]      rdata
);
	import kpi_pkg::*;

	logic [31:0] mem [0:(1 << MAT_AW)-1];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata <= mem[req.addr];
	end
endmodule

@@ design/kpi_divider.sv @@
// Restoring divider: (num << 16) / den, one quotient bit per cycle.
module kpi_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [16:0] quo
);
	import kpi_pkg::*;

	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [15:0] numlo_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic [33:0] sh;
	logic [33:0] diff;

	// numerator is num * 2^16 and num < den: remainder starts at num >> 1,
	// then num[0] and 16 zeros shift in msb first
	assign sh   = {rem_q, numlo_q[15]};
	assign diff = sh - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q   <= 1'b1;
				cnt_q   <= 5'd0;
				rem_q   <= {2'b00, num[31:1]};
				numlo_q <= {num[0], 15'd0};
				den_q   <= den;
				quo     <= '0;
			end else if (run_q) begin
				numlo_q <= {numlo_q[14:0], 1'b0};
				if (!diff[33]) begin
					rem_q <= diff[32:0];
					quo   <= {quo[15:0], 1'b1};
				end else begin
					rem_q <= sh[32:0];
					quo   <= {quo[15:0], 1'b0};
				end
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd16) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end
endmodule

@@ tb/tb.sv @@
// Testbench for keyframe_pose_interpolator: directed and random table writes and pose queries.
`timescale 1ns / 1ps

module tb;
	import kpi_pkg::*;

	typedef struct {
		action_t     act;
		logic [5:0]  key;
		logic [4:0]  jnt;
		logic [3:0]  el;
		logic [31:0] wv;
		logic [31:0] qt;
	} word_t;

	typedef struct {
		logic [4:0]  jnt;
		logic [1:0]  row;
		logic [31:0] col [4];
		logic        last;
	} pose_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] action = ACT_NONE;
	logic [5:0] key_slot = '0;
	logic [4:0] joint_id = '0;
	logic [3:0] element_slot = '0;
	logic signed [31:0] write_value = '0;
	logic [31:0] query_time = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [6:0] cfg_data = '0;
	logic strobe;
	logic [4:0] out_joint;
	logic [1:0] row_number;
	logic signed [31:0] elem_a, elem_b, elem_c, elem_d;
	logic last_row;

	keyframe_pose_interpolator dut (.*);

	always #1 clk = ~clk;

	// predictor state, updated when the block accepts a word
	logic [31:0] key_times [MAX_KEYS];
	logic [31:0] key_mats [MAX_KEYS*MAX_JOINTS*16];
	logic [6:0]  key_count = 7'd2;

	// generator's view of what has been written
	logic [31:0] gen_times [MAX_KEYS];
	bit elem_written [MAX_KEYS*MAX_JOINTS*16];

	word_t     pending_words [$];
	pose_row_t pose_rows_due [$];
	int gap_pct = 0;
	int errors = 0;
	int queries_sent = 0;
	int rows_checked = 0;

	function automatic int mat_idx(int k, int j, int e);
		return (k * MAX_JOINTS + j) * 16 + e;
	endfunction

	function automatic int eff_keys(logic [6:0] v);
		if (v < 2) return 2;
		if (v > MAX_KEYS) return MAX_KEYS;
		return v;
	endfunction

	function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, int unsigned f);
		longint sa, sb, prod;
		sa = longint'(signed'(a));
		sb = longint'(signed'(b));
		prod = (sb - sa) * longint'(f);
		return 32'(sa + (prod >>> 16));
	endfunction

	task automatic apply_word(word_t w);
		int n, lo;
		bit found;
		int unsigned f;
		pose_row_t r;
		case (w.act)
			ACT_WTIME: key_times[w.key] = w.wv;
			ACT_WELEM: key_mats[mat_idx(w.key, w.jnt, w.el)] = w.wv;
			ACT_QUERY: begin
				n = eff_keys(key_count);
				lo = n - 2;
				found = 0;
				for (int i = 0; i + 1 < n; i++) begin
					if (key_times[i+1] > w.qt) begin
						lo = i;
						found = 1;
						break;
					end
				end
				if (!found)
					f = 65536;
				else if (w.qt <= key_times[lo])
					f = 0;
				else
					f = int'(((64'(w.qt - key_times[lo])) << 16) /
						64'(key_times[lo+1] - key_times[lo]));
				for (int rr = 0; rr < 4; rr++) begin
					r.jnt = w.jnt;
					r.row = 2'(rr);
					for (int c = 0; c < 4; c++)
						r.col[c] = blend(key_mats[mat_idx(lo, w.jnt, rr*4+c)],
							key_mats[mat_idx(lo+1, w.jnt, rr*4+c)], f);
					r.last = (rr == 3);
					pose_rows_due.push_back(r);
				end
				queries_sent++;
			end
			default: ;
		endcase
	endtask

	// driver
	always @(posedge clk) begin
		word_t w;
		if (start && !busy)
			apply_word(pending_words.pop_front());
		if (start && busy) begin
			// hold the current word
		end else if (pending_words.size() > 0 && $urandom_range(99) >= gap_pct) begin
			w = pending_words[0];
			start <= 1'b1;
			action <= w.act;
			key_slot <= w.key;
			joint_id <= w.jnt;
			element_slot <= w.el;
			write_value <= w.wv;
			query_time <= w.qt;
		end else begin
			start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		pose_row_t e;
		if (arst_n && strobe) begin
			if (pose_rows_due.size() == 0) begin
				$error("row with no query pending: joint %0d row %0d", out_joint, row_number);
				errors++;
			end else begin
				e = pose_rows_due.pop_front();
				rows_checked++;
				if (out_joint !== e.jnt) begin
					$error("out_joint exp %0d got %0d", e.jnt, out_joint); errors++;
				end
				if (row_number !== e.row) begin
					$error("row_number exp %0d got %0d", e.row, row_number); errors++;
				end
				if (elem_a !== e.col[0]) begin
					$error("elem_a exp %h got %h", e.col[0], elem_a); errors++;
				end
				if (elem_b !== e.col[1]) begin
					$error("elem_b exp %h got %h", e.col[1], elem_b); errors++;
				end
				if (elem_c !== e.col[2]) begin
					$error("elem_c exp %h got %h", e.col[2], elem_c); errors++;
				end
				if (elem_d !== e.col[3]) begin
					$error("elem_d exp %h got %h", e.col[3], elem_d); errors++;
				end
				if (last_row !== e.last) begin
					$error("last_row exp %0d got %0d", e.last, last_row); errors++;
				end
			end
		end
	end

	function automatic word_t blank_word(action_t a);
		word_t w;
		w.act = a;
		w.key = 6'($urandom);
		w.jnt = 5'($urandom);
		w.el = 4'($urandom);
		w.wv = $urandom;
		w.qt = $urandom;
		return w;
	endfunction

	task automatic queue_word(word_t w);
		if (w.act == ACT_WTIME) gen_times[w.key] = w.wv;
		if (w.act == ACT_WELEM) elem_written[mat_idx(w.key, w.jnt, w.el)] = 1;
		pending_words.push_back(w);
	endtask

	task automatic queue_time(int k, logic [31:0] t);
		word_t w;
		w = blank_word(ACT_WTIME);
		w.key = 6'(k);
		w.wv = t;
		queue_word(w);
	endtask

	task automatic queue_elem(int k, int j, int e, logic [31:0] v);
		word_t w;
		w = blank_word(ACT_WELEM);
		w.key = 6'(k);
		w.jnt = 5'(j);
		w.el = 4'(e);
		w.wv = v;
		queue_word(w);
	endtask

	task automatic queue_query(int j, logic [31:0] t);
		word_t w;
		w = blank_word(ACT_QUERY);
		w.jnt = 5'(j);
		w.qt = t;
		queue_word(w);
	endtask

	// lower key a query at time t will use, from the queued key times
	function automatic int find_lo(int n, logic [31:0] t);
		for (int i = 0; i + 1 < n; i++)
			if (gen_times[i+1] > t) return i;
		return n - 2;
	endfunction

	function automatic bit pair_loaded(int j, int lo);
		for (int k = lo; k <= lo + 1; k++)
			for (int e = 0; e < 16; e++)
				if (!elem_written[mat_idx(k, j, e)]) return 0;
		return 1;
	endfunction

	function automatic logic [31:0] pick_time(int n);
		int k;
		k = $urandom_range(n - 1);
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'd0;
			2: return 32'hFFFF_FFFF;
			3: return gen_times[k];
			default: return gen_times[k] + $urandom_range(32'h3_0000);
		endcase
	endfunction

	task automatic wait_idle();
		wait (pending_words.size() == 0 && !start && pose_rows_due.size() == 0);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_keys_in_use(logic [6:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		key_count = v;
	endtask

	task automatic random_phase(logic [6:0] cfg, int gap, int count);
		int n, j;
		logic [31:0] t, v;
		wait_idle();
		write_keys_in_use(cfg);
		gap_pct = gap;
		n = eff_keys(cfg);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: begin
					j = $urandom_range(MAX_JOINTS - 1);
					t = pick_time(n);
					if (!pair_loaded(j, find_lo(n, t))) j = MAX_JOINTS - 1;
					// past the last key the pair is always keys n-2 and n-1
					if (!pair_loaded(j, find_lo(n, t))) t = 32'hFFFF_FFFF;
					queue_query(j, t);
				end
				5, 6: begin
					v = ($urandom_range(3) == 0) ?
						{1'($urandom_range(1)), 31'h7FFF_FFFF} : $urandom;
					queue_elem($urandom_range(MAX_KEYS - 1), $urandom_range(MAX_JOINTS - 1),
						$urandom_range(15), v);
				end
				7: queue_time($urandom_range(MAX_KEYS - 1), $urandom);
				8: queue_time($urandom_range(MAX_KEYS - 1),
					gen_times[$urandom_range(MAX_KEYS - 1)] + $urandom_range(32'h2_0000));
				default: queue_word(blank_word(ACT_NONE));
			endcase
		end
	endtask

	initial begin
		for (int k = 0; k < MAX_KEYS; k++) begin
			key_times[k] = '0;
			gen_times[k] = '0;
		end
		for (int i = 0; i < MAX_KEYS*MAX_JOINTS*16; i++) key_mats[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// table load: ascending key times with a repeated pair for a zero interval
		for (int k = 0; k < MAX_KEYS; k++)
			queue_time(k, (k == 3) ? 32'h6_0000 : k * 32'h3_0000);
		// last joint holds the final pair of every key count used below
		for (int k = 0; k < MAX_KEYS; k++)
			if (k < 8 || k >= MAX_KEYS - 2)
				for (int e = 0; e < 16; e++)
					queue_elem(k, MAX_JOINTS - 1, e, $urandom);
		for (int k = 0; k < 2; k++)
			for (int e = 0; e < 16; e++)
				queue_elem(k, 0, e, $urandom);

		// directed, two keys
		queue_elem(0, 0, 0, 32'h8000_0000);
		queue_elem(1, 0, 0, 32'h7FFF_FFFF);
		queue_elem(0, 0, 15, 32'h7FFF_FFFF);
		queue_elem(1, 0, 15, 32'h8000_0000);
		queue_query(0, 32'd0);
		queue_query(0, 32'h1_8000);
		queue_query(0, 32'h3_0000);
		queue_query(0, 32'hFFFF_FFFF);
		queue_query(MAX_JOINTS - 1, 32'h2_FFFF);
		queue_word(blank_word(ACT_NONE));
		queue_query(MAX_JOINTS - 1, 32'h0_0001);
		wait_idle();

		// directed, wider tables: zero interval, exact key hits, past the end
		write_keys_in_use(7'd8);
		queue_query(MAX_JOINTS - 1, 32'h6_0000);
		queue_query(MAX_JOINTS - 1, 32'h6_8000);
		queue_query(MAX_JOINTS - 1, 32'h15_0000);
		queue_query(MAX_JOINTS - 1, 32'h15_0001);
		queue_query(0, 32'h4_0000);
		wait_idle();
		write_keys_in_use(7'd127);
		queue_query(MAX_JOINTS - 1, 32'hBD_0000);
		queue_query(MAX_JOINTS - 1, 32'hFFFF_FFFF);
		queue_query(MAX_JOINTS - 1, 32'hBB_8000);

		random_phase(7'd2, 0, 30);
		random_phase(7'd64, 66, 30);
		random_phase(7'd0, 27, 30);
		random_phase(7'd5, 66, 30);
		random_phase(7'd127, 0, 30);
		random_phase(7'd1, 27, 30);
		random_phase(7'd8, 0, 30);
		wait_idle();

		$display("Covered %0d queries and %0d checked rows across key counts 0 to 127,",
			queries_sent, rows_checked);
		$display("with table writes, ignored words and random sender gaps.");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end
endmodule

@@ filelist.f @@
design/kpi_pkg.sv
design/kpi_mat_ram.sv
design/kpi_divider.sv
design/keyframe_pose_interpolator.sv
tb/tb.sv
